FILE: rtl/core/fixed_weight_ternary_sampler_assert.svh
// Assertion macros for the sampler checker.
`ifndef FIXED_WEIGHT_TERNARY_SAMPLER_ASSERT_SVH
`define FIXED_WEIGHT_TERNARY_SAMPLER_ASSERT_SVH

// Checked only while reset is released.
`define FTWS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checked at every edge, reset included.
`define FTWS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: rtl/core/ftws_pkg.sv
// Package: types and constants of the fixed-weight ternary sampler.
`timescale 1ns / 1ps

package ftws_pkg;

    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 10;
    localparam int DATA_W     = 32;
    localparam int WEIGHT_W   = 11;
    localparam int COEF_W     = 2;
    localparam int CNT_W      = 9;
    localparam int NUM_BLOCKS = 8;
    localparam int BLK_W      = 3;
    localparam int BLOCK_SHIFT = 8;
    localparam int SIGN_GROUP_SHIFT = 4;

    localparam logic [DATA_W-1:0] FULL_WORD  = 32'hffff_ffff;
    localparam logic [COEF_W-1:0] COEF_ZERO  = 2'b00;
    localparam logic [COEF_W-1:0] COEF_PLUS  = 2'b01;
    localparam logic [COEF_W-1:0] COEF_MINUS = 2'b11;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 3'd0,
        CMD_SIGN      = 3'd1,
        CMD_POS       = 3'd2,
        CMD_READ_COEF = 3'd3,
        CMD_READ_BLK  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_EXEC,
        OP_DIV1,
        OP_DIV2,
        OP_CHECK,
        OP_RD_IDX,
        OP_RD_DEST,
        OP_WR_DEST,
        OP_WR_IDX,
        OP_CAP_COEF,
        OP_CLEAR,
        OP_RESULT
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_DIV1,
        ST_DIV1_WAIT,
        ST_DIV2,
        ST_DIV2_WAIT,
        ST_CHECK,
        ST_RD_IDX,
        ST_RD_DEST,
        ST_WR_DEST,
        ST_WR_IDX,
        ST_CAP_COEF,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic   accept;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ovf;
        logic             pos_go;
        logic             div_busy;
        logic             idx_ok;
        logic             clr_last;
    } t_dp_status;

endpackage

FILE: rtl/core/ftws_in_if.sv
// Input channel: valid/ready with command, address and data.
`timescale 1ns / 1ps

interface ftws_in_if;
    logic                            valid;
    logic                            ready;
    logic [ftws_pkg::CMD_W-1:0]      command;
    logic [ftws_pkg::ADDR_W-1:0]     address;
    logic [ftws_pkg::DATA_W-1:0]     data;

    modport source (output valid, output command, output address, output data, input ready);
    modport sink   (input valid, input command, input address, input data, output ready);
endinterface

FILE: rtl/core/ftws_out_if.sv
// Output channel: valid/ready with the result fields.
`timescale 1ns / 1ps

interface ftws_out_if;
    logic                               valid;
    logic                               ready;
    logic                               accepted;
    logic signed [ftws_pkg::COEF_W-1:0] coefficient;
    logic [ftws_pkg::CNT_W-1:0]         block_count;
    logic [ftws_pkg::WEIGHT_W-1:0]      placed;
    logic                               complete;
    logic                               word_overflow;

    modport source (output valid, output accepted, output coefficient, output block_count,
                    output placed, output complete, output word_overflow, input ready);
    modport sink   (input valid, input accepted, input coefficient, input block_count,
                    input placed, input complete, input word_overflow, output ready);
endinterface

FILE: rtl/core/ftws_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ftws_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ftws_pkg::DATA_W-1:0] i_dividend,
    input  logic [ftws_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_busy,
    output logic [ftws_pkg::DATA_W-1:0] o_quotient
);

    localparam int W      = ftws_pkg::DATA_W;
    localparam int STEP_W = $clog2(W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(W - 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_quo;
    logic [W-1:0]      r_den;

    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              ge;

    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/ftws_datapath.sv
// Datapath: coefficient store, sign words, block counts, counters and divider.
`timescale 1ns / 1ps

module ftws_datapath #(
    parameter int DIMENSION = 1024,
    parameter int MAX_WORDS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ftws_pkg::WEIGHT_W-1:0]       i_cfg_wdata,
    input  logic [ftws_pkg::CMD_W-1:0]          i_command,
    input  logic [ftws_pkg::ADDR_W-1:0]         i_address,
    input  logic [ftws_pkg::DATA_W-1:0]         i_data,
    input  ftws_pkg::t_dp_cmd                   i_cmd,
    output ftws_pkg::t_dp_status                o_status,
    output logic                                o_accepted,
    output logic signed [ftws_pkg::COEF_W-1:0]  o_coefficient,
    output logic [ftws_pkg::CNT_W-1:0]          o_block_count,
    output logic [ftws_pkg::WEIGHT_W-1:0]       o_placed,
    output logic                                o_complete,
    output logic                                o_word_overflow
);

    localparam int IW    = $clog2(DIMENSION);
    localparam int NW    = $clog2(DIMENSION + 1);
    localparam int XW    = ((NW > ftws_pkg::WEIGHT_W) ? NW : ftws_pkg::WEIGHT_W) + 1;
    localparam int WW    = $clog2(MAX_WORDS + 1);
    localparam int SLOTS = (MAX_WORDS + 15) / 16;
    localparam int SW    = $clog2(SLOTS);
    localparam int DW    = ftws_pkg::DATA_W;
    localparam int CW    = ftws_pkg::COEF_W;
    localparam int KW    = ftws_pkg::CNT_W;
    localparam int BW    = ftws_pkg::BLK_W;

    // Coefficient store
    logic [CW-1:0] r_store [DIMENSION];
    logic [CW-1:0] r_rdata;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [CW-1:0] mem_wd;
    logic [IW-1:0] mem_ra;

    // Control state
    logic [ftws_pkg::WEIGHT_W-1:0] r_weight;
    logic [ftws_pkg::WEIGHT_W-1:0] r_placed;
    logic [WW-1:0]                 r_word_idx;
    logic [KW-1:0]                 r_cnt [ftws_pkg::NUM_BLOCKS];
    logic [IW-1:0]                 r_clr_addr;

    // Item and work registers
    logic [ftws_pkg::CMD_W-1:0]    r_cmd;
    logic [ftws_pkg::ADDR_W-1:0]   r_addr;
    logic [DW-1:0]                 r_data;
    logic [DW-1:0]                 r_sign [SLOTS];
    logic [WW-1:0]                 r_wi;
    logic [IW-1:0]                 r_dest;
    logic [NW-1:0]                 r_n;
    logic [IW-1:0]                 r_idx;
    logic [CW-1:0]                 r_moved;
    logic                          r_sign_bit;
    logic                          r_acc;
    logic                          r_ovf;
    logic [CW-1:0]                 r_coef;
    logic [KW-1:0]                 r_bcnt;

    // Result registers
    logic                          r_res_acc;
    logic [CW-1:0]                 r_res_coef;
    logic [KW-1:0]                 r_res_bcnt;
    logic [ftws_pkg::WEIGHT_W-1:0] r_res_placed;
    logic                          r_res_complete;
    logic                          r_res_ovf;

    // Divider
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_busy;
    logic [DW-1:0] div_quo;

    logic [XW-1:0] dest_full;
    logic          pos_go;
    logic          ovf;
    logic          idx_ok;
    logic          addr_in_dim;
    logic          addr_in_blk;
    logic [DW-1:0] sign_shifted;

    logic [BW-1:0] blk_sel;
    logic [KW-1:0] cnt_cur;
    logic [KW-1:0] cnt_dec;
    logic [KW-1:0] cnt_new;
    logic          cnt_sub;
    logic          cnt_add;

    ftws_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_comb begin
        dest_full   = XW'(DIMENSION) - XW'(r_weight) + XW'(r_placed);
        pos_go      = (XW'(r_weight) <= XW'(DIMENSION)) && (r_placed < r_weight);
        ovf         = (32'(r_word_idx) >= 32'(MAX_WORDS));
        idx_ok      = (div_quo < DW'(r_n));
        addr_in_dim = (32'(r_addr) < 32'(DIMENSION));
        addr_in_blk = (32'(r_addr) < 32'(ftws_pkg::NUM_BLOCKS));
        // sign bit sits one above the word's position within its group
        sign_shifted = r_sign[SW'(r_wi >> ftws_pkg::SIGN_GROUP_SHIFT)] >> r_wi[3:0];

        div_start    = (i_cmd.op == ftws_pkg::OP_DIV1) || (i_cmd.op == ftws_pkg::OP_DIV2);
        div_dividend = (i_cmd.op == ftws_pkg::OP_DIV1) ? ftws_pkg::FULL_WORD : r_data;
        div_divisor  = (i_cmd.op == ftws_pkg::OP_DIV1) ? DW'(r_n) : div_quo;
    end

    always_comb begin
        o_status.cmd      = r_cmd;
        o_status.ovf      = ovf;
        o_status.pos_go   = pos_go;
        o_status.div_busy = div_busy;
        o_status.idx_ok   = idx_ok;
        o_status.clr_last = (r_clr_addr == IW'(DIMENSION - 1));
    end

    // Store port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_dest;
        mem_wd = r_moved;
        case (i_cmd.op)
            ftws_pkg::OP_WR_DEST: begin
                mem_we = 1'b1;
            end
            ftws_pkg::OP_WR_IDX: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = r_sign_bit ? ftws_pkg::COEF_PLUS : ftws_pkg::COEF_MINUS;
            end
            ftws_pkg::OP_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
                mem_wd = ftws_pkg::COEF_ZERO;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase

        case (i_cmd.op)
            ftws_pkg::OP_RD_IDX:  mem_ra = r_idx;
            ftws_pkg::OP_RD_DEST: mem_ra = r_dest;
            default:              mem_ra = IW'(r_addr);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= mem_wd;
        end
        r_rdata <= r_store[mem_ra];
    end

    // Block count update: the old value leaves, the new one enters
    always_comb begin
        case (i_cmd.op)
            ftws_pkg::OP_WR_DEST: begin
                blk_sel = BW'(32'(r_dest) >> ftws_pkg::BLOCK_SHIFT);
                cnt_sub = (r_rdata != ftws_pkg::COEF_ZERO);
                cnt_add = (r_moved != ftws_pkg::COEF_ZERO);
            end
            ftws_pkg::OP_WR_IDX: begin
                // old entry at idx equals the moved value in both swap cases
                blk_sel = BW'(32'(r_idx) >> ftws_pkg::BLOCK_SHIFT);
                cnt_sub = (r_moved != ftws_pkg::COEF_ZERO);
                cnt_add = 1'b1;
            end
            default: begin
                blk_sel = BW'(r_addr);
                cnt_sub = 1'b0;
                cnt_add = 1'b0;
            end
        endcase
        cnt_cur = r_cnt[blk_sel];
        cnt_dec = (cnt_sub && (cnt_cur != '0)) ? cnt_cur - 1'b1 : cnt_cur;
        cnt_new = cnt_add ? cnt_dec + 1'b1 : cnt_dec;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight   <= '0;
            r_placed   <= '0;
            r_word_idx <= '0;
            r_clr_addr <= '0;
            for (int b = 0; b < ftws_pkg::NUM_BLOCKS; b++) begin
                r_cnt[b] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_weight <= i_cfg_wdata;
            end
            case (i_cmd.op)
                ftws_pkg::OP_EXEC: begin
                    if ((r_cmd == ftws_pkg::CMD_POS) && !ovf) begin
                        r_word_idx <= r_word_idx + 1'b1;
                    end
                end
                ftws_pkg::OP_WR_DEST: begin
                    r_cnt[blk_sel] <= cnt_new;
                end
                ftws_pkg::OP_WR_IDX: begin
                    r_cnt[blk_sel] <= cnt_new;
                    r_placed       <= r_placed + 1'b1;
                end
                ftws_pkg::OP_CLEAR: begin
                    r_placed   <= '0;
                    r_word_idx <= '0;
                    for (int b = 0; b < ftws_pkg::NUM_BLOCKS; b++) begin
                        r_cnt[b] <= '0;
                    end
                    if (r_clr_addr == IW'(DIMENSION - 1)) begin
                        r_clr_addr <= '0;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Item and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_command;
            r_addr <= i_address;
            r_data <= i_data;
            r_acc  <= 1'b0;
            r_ovf  <= 1'b0;
            r_coef <= ftws_pkg::COEF_ZERO;
            r_bcnt <= '0;
        end
        case (i_cmd.op)
            ftws_pkg::OP_EXEC: begin
                case (r_cmd)
                    ftws_pkg::CMD_SIGN: begin
                        if (32'(r_addr) < 32'(SLOTS)) begin
                            r_sign[SW'(r_addr)] <= r_data;
                        end
                    end
                    ftws_pkg::CMD_POS: begin
                        r_ovf  <= ovf;
                        r_wi   <= r_word_idx;
                        r_dest <= IW'(dest_full);
                        r_n    <= NW'(dest_full + 1'b1);
                    end
                    ftws_pkg::CMD_READ_BLK: begin
                        r_bcnt <= addr_in_blk ? cnt_cur : '0;
                    end
                    default: begin
                    end
                endcase
            end
            ftws_pkg::OP_CHECK: begin
                r_idx      <= IW'(div_quo);
                r_sign_bit <= sign_shifted[1];
            end
            ftws_pkg::OP_RD_DEST: begin
                r_moved <= r_rdata;
            end
            ftws_pkg::OP_WR_IDX: begin
                r_acc <= 1'b1;
            end
            ftws_pkg::OP_CAP_COEF: begin
                r_coef <= addr_in_dim ? r_rdata : ftws_pkg::COEF_ZERO;
            end
            ftws_pkg::OP_RESULT: begin
                r_res_acc      <= r_acc;
                r_res_coef     <= r_coef;
                r_res_bcnt     <= r_bcnt;
                r_res_placed   <= r_placed;
                r_res_complete <= (r_placed == r_weight);
                r_res_ovf      <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    assign o_accepted      = r_res_acc;
    assign o_coefficient   = r_res_coef;
    assign o_block_count   = r_res_bcnt;
    assign o_placed        = r_res_placed;
    assign o_complete      = r_res_complete;
    assign o_word_overflow = r_res_ovf;

endmodule

FILE: rtl/core/ftws_ctrl.sv
// Controller: sequences each item through the datapath and owns the handshakes.
`timescale 1ns / 1ps

module ftws_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ftws_pkg::t_dp_status i_status,
    output ftws_pkg::t_dp_cmd    o_cmd
);

    ftws_pkg::t_state r_state;
    ftws_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftws_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.op     = ftws_pkg::OP_NONE;

        case (r_state)
            ftws_pkg::ST_INIT: begin
                o_cmd.op = ftws_pkg::OP_CLEAR;
                if (i_status.clr_last) begin
                    n_state = ftws_pkg::ST_IDLE;
                end
            end
            ftws_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ftws_pkg::ST_EXEC;
                end
            end
            ftws_pkg::ST_EXEC: begin
                o_cmd.op = ftws_pkg::OP_EXEC;
                case (i_status.cmd)
                    ftws_pkg::CMD_CLEAR:     n_state = ftws_pkg::ST_CLEAR;
                    ftws_pkg::CMD_POS: begin
                        if (i_status.ovf || !i_status.pos_go) begin
                            n_state = ftws_pkg::ST_DONE;
                        end else begin
                            n_state = ftws_pkg::ST_DIV1;
                        end
                    end
                    ftws_pkg::CMD_READ_COEF: n_state = ftws_pkg::ST_CAP_COEF;
                    default:                 n_state = ftws_pkg::ST_DONE;
                endcase
            end
            ftws_pkg::ST_DIV1: begin
                o_cmd.op = ftws_pkg::OP_DIV1;
                n_state  = ftws_pkg::ST_DIV1_WAIT;
            end
            ftws_pkg::ST_DIV1_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ftws_pkg::ST_DIV2;
                end
            end
            ftws_pkg::ST_DIV2: begin
                o_cmd.op = ftws_pkg::OP_DIV2;
                n_state  = ftws_pkg::ST_DIV2_WAIT;
            end
            ftws_pkg::ST_DIV2_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ftws_pkg::ST_CHECK;
                end
            end
            ftws_pkg::ST_CHECK: begin
                o_cmd.op = ftws_pkg::OP_CHECK;
                n_state  = i_status.idx_ok ? ftws_pkg::ST_RD_IDX : ftws_pkg::ST_DONE;
            end
            ftws_pkg::ST_RD_IDX: begin
                o_cmd.op = ftws_pkg::OP_RD_IDX;
                n_state  = ftws_pkg::ST_RD_DEST;
            end
            ftws_pkg::ST_RD_DEST: begin
                o_cmd.op = ftws_pkg::OP_RD_DEST;
                n_state  = ftws_pkg::ST_WR_DEST;
            end
            ftws_pkg::ST_WR_DEST: begin
                o_cmd.op = ftws_pkg::OP_WR_DEST;
                n_state  = ftws_pkg::ST_WR_IDX;
            end
            ftws_pkg::ST_WR_IDX: begin
                o_cmd.op = ftws_pkg::OP_WR_IDX;
                n_state  = ftws_pkg::ST_DONE;
            end
            ftws_pkg::ST_CAP_COEF: begin
                o_cmd.op = ftws_pkg::OP_CAP_COEF;
                n_state  = ftws_pkg::ST_DONE;
            end
            ftws_pkg::ST_CLEAR: begin
                o_cmd.op = ftws_pkg::OP_CLEAR;
                if (i_status.clr_last) begin
                    n_state = ftws_pkg::ST_DONE;
                end
            end
            ftws_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = ftws_pkg::OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = ftws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ftws_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/fixed_weight_ternary_sampler.sv
// Top level of the fixed-weight ternary sampler.
//
//  channel    | dir | transfer when   | payload
//  -----------+-----+-----------------+------------------------------------------
//  i_item     | in  | valid & ready   | command, address, data
//  o_result   | out | valid & ready   | accepted, coefficient, block_count,
//             |     |                 | placed, complete, word_overflow
//  i_cfg_*    | in  | i_cfg_we        | weight
//
// Sign load, block read, unused commands and undivided position words run the
// execute and done states; a coefficient read adds a capture state. A placed
// position word makes two passes of the one-bit-per-cycle divider, then a swap
// on the store (read idx, read dest, write dest, write idx); a rejected one
// skips the swap. A clear zeroes one store entry per cycle.
// After reset the same pass runs over the whole store before i_item.ready rises.
// The next item is taken while a result waits in the output register.
`timescale 1ns / 1ps

module fixed_weight_ternary_sampler #(
    parameter int DIMENSION = 1024,
    parameter int MAX_WORDS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ftws_pkg::WEIGHT_W-1:0] i_cfg_wdata,
    ftws_in_if.sink                       i_item,
    ftws_out_if.source                    o_result
);

    ftws_pkg::t_dp_cmd    dp_cmd;
    ftws_pkg::t_dp_status dp_status;
    logic                 in_ready;
    logic                 out_valid;

    ftws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    ftws_datapath #(
        .DIMENSION (DIMENSION),
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_item.command),
        .i_address       (i_item.address),
        .i_data          (i_item.data),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .o_accepted      (o_result.accepted),
        .o_coefficient   (o_result.coefficient),
        .o_block_count   (o_result.block_count),
        .o_placed        (o_result.placed),
        .o_complete      (o_result.complete),
        .o_word_overflow (o_result.word_overflow)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

endmodule

FILE: rtl/core/ftws_checker.sv
// Port-level checks of the sampler, bound to the top level.
`timescale 1ns / 1ps
`include "fixed_weight_ternary_sampler_assert.svh"

module ftws_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_accepted,
    input logic [ftws_pkg::COEF_W-1:0]   i_coefficient,
    input logic [ftws_pkg::CNT_W-1:0]    i_block_count,
    input logic [ftws_pkg::WEIGHT_W-1:0] i_placed,
    input logic                          i_complete,
    input logic                          i_word_overflow
);

    `FTWS_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_accepted, i_coefficient, i_block_count, i_placed, i_complete, i_word_overflow}), "result changed while stalled")
    `FTWS_ASSERT(a_one_kind, i_clk, i_rst_n, i_out_valid |-> $onehot0({i_accepted, i_word_overflow, i_coefficient != 2'b00, i_block_count != '0}), "result mixes kinds")
    `FTWS_ASSERT(a_coef_ternary, i_clk, i_rst_n, i_out_valid |-> i_coefficient != 2'b10, "coefficient not ternary")
    `FTWS_ASSERT(a_accept_placed, i_clk, i_rst_n, i_out_valid && i_accepted |-> i_placed != '0, "placement with zero count")
    `FTWS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind fixed_weight_ternary_sampler ftws_checker u_ftws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_accepted      (o_result.accepted),
    .i_coefficient   (o_result.coefficient),
    .i_block_count   (o_result.block_count),
    .i_placed        (o_result.placed),
    .i_complete      (o_result.complete),
    .i_word_overflow (o_result.word_overflow)
);

FILE: sim/fixed_weight_ternary_sampler_test.sv
// Self-checking testbench for the fixed-weight ternary sampler.
`timescale 1ns / 1ps

module fixed_weight_ternary_sampler_test;
    import ftws_pkg::*;

    localparam int DIMENSION    = 1024;
    localparam int MAX_WORDS    = 128;
    localparam int SIGN_SLOTS   = (MAX_WORDS + 15) / 16;
    localparam int WEIGHT_MAX   = (1 << WEIGHT_W) - 1;
    localparam int IDLE_PCT     = 19;
    localparam int LONG_HOLD    = 500;
    localparam int TAIL_CYCLES  = DIMENSION + 100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_TARGET  = 1040;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [CMD_W-1:0]  CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI = 3'd7;
    localparam int unsigned       SIGN_SHIFT_MASK = 'h0f;
    localparam logic [DATA_W-1:0] SIGN_SELECT     = 'h02;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } sampler_item_t;

    typedef struct packed {
        logic                accepted;
        logic [COEF_W-1:0]   coefficient;
        logic [CNT_W-1:0]    block_count;
        logic [WEIGHT_W-1:0] placed;
        logic                complete;
        logic                word_overflow;
    } sampler_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [WEIGHT_W-1:0] i_cfg_wdata = '0;

    ftws_in_if  item_ch ();
    ftws_out_if result_ch ();

    fixed_weight_ternary_sampler #(
        .DIMENSION(DIMENSION),
        .MAX_WORDS(MAX_WORDS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    always #1 i_clk = ~i_clk;

    // Sampler state as the block should hold it
    logic [COEF_W-1:0]   coef_store [DIMENSION];
    logic [CNT_W-1:0]    blk_count [NUM_BLOCKS];
    logic [DATA_W-1:0]   sign_word [SIGN_SLOTS];
    logic [WEIGHT_W-1:0] placed_total;
    int unsigned         words_used;
    logic [WEIGHT_W-1:0] weight_reg;

    sampler_item_t   pending_items [$];
    sampler_result_t expected_results [$];
    sampler_item_t   offered_item;

    int  fail_count = 0;
    int  stim_count = 0;
    int  cycle_count = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    logic calm = 1'b0;

    function automatic void clear_model();
        foreach (coef_store[i]) coef_store[i] = COEF_ZERO;
        foreach (blk_count[i]) blk_count[i] = '0;
        placed_total = '0;
        words_used = 0;
    endfunction

    function automatic void set_coef(int unsigned pos, logic [COEF_W-1:0] value);
        int unsigned blk;
        blk = pos >> BLOCK_SHIFT;
        if (coef_store[pos] != COEF_ZERO && blk_count[blk] != 0)
            blk_count[blk]--;
        coef_store[pos] = value;
        if (value != COEF_ZERO)
            blk_count[blk]++;
    endfunction

    function automatic sampler_result_t place_and_predict(sampler_item_t it);
        sampler_result_t r;
        int unsigned wi, dest, span, remain, idx;
        logic [DATA_W-1:0] sw;
        logic [COEF_W-1:0] moved;
        r = '0;
        case (it.command)
            CMD_CLEAR: clear_model();
            CMD_SIGN: begin
                if (it.address < SIGN_SLOTS)
                    sign_word[it.address] = it.data;
            end
            CMD_POS: begin
                if (words_used >= MAX_WORDS) begin
                    r.word_overflow = 1'b1;
                end else begin
                    wi = words_used;
                    words_used++;
                    if (weight_reg <= DIMENSION && placed_total < weight_reg) begin
                        dest = DIMENSION - weight_reg + placed_total;
                        span = dest + 1;
                        remain = FULL_WORD / span;
                        idx = it.data / remain;
                        // the division alone can land one past the range
                        if (idx < span) begin
                            sw = sign_word[(wi >> SIGN_GROUP_SHIFT) % SIGN_SLOTS];
                            moved = coef_store[idx];
                            set_coef(dest, moved);
                            set_coef(idx, ((sw >> (wi & SIGN_SHIFT_MASK)) & SIGN_SELECT) != 0
                                          ? COEF_PLUS : COEF_MINUS);
                            placed_total++;
                            r.accepted = 1'b1;
                        end
                    end
                end
            end
            CMD_READ_COEF: r.coefficient = coef_store[it.address];
            CMD_READ_BLK: begin
                if (it.address < NUM_BLOCKS)
                    r.block_count = blk_count[it.address];
            end
            default: ;
        endcase
        r.placed = placed_total;
        r.complete = (placed_total == weight_reg);
        return r;
    endfunction

    // Item driver
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            offer = item_ch.valid;
            if (item_ch.valid && item_ch.ready) begin
                expected_results.push_back(place_and_predict(offered_item));
                offer = 1'b0;
            end
            if (!offer && pending_items.size() != 0 &&
                (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
                offered_item = pending_items.pop_front();
                item_ch.command <= offered_item.command;
                item_ch.address <= offered_item.address;
                item_ch.data <= offered_item.data;
                offer = 1'b1;
            end
            item_ch.valid <= offer;
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        sampler_result_t want, got;
        logic take;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got.accepted = result_ch.accepted;
                got.coefficient = result_ch.coefficient;
                got.block_count = result_ch.block_count;
                got.placed = result_ch.placed;
                got.complete = result_ch.complete;
                got.word_overflow = result_ch.word_overflow;
                if (expected_results.size() == 0) begin
                    if (fail_count < SHOWN_ERRORS)
                        $display("%0t: result with nothing expected: acc=%0d coef=%0d cnt=%0d",
                                 $realtime, got.accepted, $signed(got.coefficient),
                                 got.block_count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted || got.coefficient !== want.coefficient ||
                        got.block_count !== want.block_count || got.placed !== want.placed ||
                        got.complete !== want.complete ||
                        got.word_overflow !== want.word_overflow) begin
                        if (fail_count < SHOWN_ERRORS) begin
                            $display("%0t: mismatch", $realtime);
                            $display("  expected acc=%0d coef=%0d cnt=%0d placed=%0d done=%0d ovf=%0d",
                                     want.accepted, $signed(want.coefficient), want.block_count,
                                     want.placed, want.complete, want.word_overflow);
                            $display("  actual   acc=%0d coef=%0d cnt=%0d placed=%0d done=%0d ovf=%0d",
                                     got.accepted, $signed(got.coefficient), got.block_count,
                                     got.placed, got.complete, got.word_overflow);
                        end
                        fail_count++;
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                take = 1'b0;
            end else begin
                take = calm || $urandom_range(99, 0) >= IDLE_PCT;
            end
            result_ch.ready <= take;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] data);
        sampler_item_t it;
        it.command = cmd;
        it.address = addr;
        it.data = data;
        pending_items.push_back(it);
        stim_count++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
    endtask

    task automatic write_weight(logic [WEIGHT_W-1:0] w);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        weight_reg = w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] position_word();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        // words near the top of the range fall into the rejection window
        if (roll < 8)
            return FULL_WORD - $urandom_range(2047, 0);
        if (roll < 11)
            return '0;
        return $urandom;
    endfunction

    initial begin
        int seq;
        int words;
        int roll;
        int w_eff;
        logic [WEIGHT_W-1:0] w;
        logic [ADDR_W-1:0] addr;

        item_ch.valid = 1'b0;
        item_ch.command = '0;
        item_ch.address = '0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
        clear_model();
        weight_reg = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: sign slots, ignored loads, spare commands, reads at the edges
        queue_item(CMD_SIGN, 0, '0);
        queue_item(CMD_SIGN, SIGN_SLOTS - 1, FULL_WORD);
        for (int s = 1; s < SIGN_SLOTS - 1; s++)
            queue_item(CMD_SIGN, s, $urandom);
        queue_item(CMD_SIGN, SIGN_SLOTS, $urandom);
        queue_item(CMD_SIGN, '1, $urandom);
        queue_item(CMD_SPARE_LO, $urandom, $urandom);
        queue_item(CMD_SPARE_HI, '1, FULL_WORD);
        queue_item(CMD_READ_COEF, 0, '0);
        queue_item(CMD_READ_COEF, '1, '0);
        queue_item(CMD_READ_BLK, 0, '0);
        queue_item(CMD_READ_BLK, NUM_BLOCKS - 1, '0);
        queue_item(CMD_READ_BLK, NUM_BLOCKS, '0);
        queue_item(CMD_READ_BLK, '1, '0);
        // weight zero: already complete, word is consumed only
        queue_item(CMD_POS, 0, $urandom);
        queue_item(CMD_CLEAR, 0, '0);

        write_weight(DIMENSION);
        queue_item(CMD_POS, 0, '0);
        queue_item(CMD_POS, 0, FULL_WORD);
        queue_item(CMD_POS, 0, 32'h7fff_ffff);
        queue_item(CMD_READ_COEF, 0, '0);
        queue_item(CMD_READ_COEF, 1, '0);
        queue_item(CMD_READ_BLK, 0, '0);

        // weight beyond the store: never accepted
        write_weight(WEIGHT_MAX);
        queue_item(CMD_POS, 0, $urandom);
        queue_item(CMD_READ_BLK, 0, '0);

        seq = 0;
        while (stim_count < ITEM_TARGET) begin
            case ($urandom_range(9, 0))
                0: w = DIMENSION;
                1: w = 0;
                2: w = WEIGHT_MAX;
                3: w = 1;
                4: w = $urandom_range(WEIGHT_MAX, DIMENSION + 1);
                default: w = $urandom_range(120, 2);
            endcase
            if (seq == 0)
                w = DIMENSION;
            write_weight(w);
            calm <= (seq == 2);
            w_eff = (w > DIMENSION) ? DIMENSION : w;

            if (seq == 0 || $urandom_range(9, 0) == 0)
                words = MAX_WORDS + 1 + $urandom_range(6, 0);
            else
                words = ((w > 90) ? 90 : w) + $urandom_range(6, 0);

            queue_item(CMD_CLEAR, $urandom, $urandom);
            if ($urandom_range(9, 0) < 3)
                for (int s = 0; s < SIGN_SLOTS; s++)
                    queue_item(CMD_SIGN, s, $urandom);

            for (int k = 0; k < words; k++) begin
                if (stim_count >= ITEM_TARGET)
                    break;
                roll = $urandom_range(99, 0);
                if (roll < 4) begin
                    queue_item($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO), $urandom, $urandom);
                end else if (roll < 6) begin
                    queue_item(CMD_SIGN, $urandom_range(DIMENSION - 1, SIGN_SLOTS), $urandom);
                end else if (roll < 8) begin
                    queue_item(CMD_CLEAR, $urandom, $urandom);
                end else if (roll < 18) begin
                    if (w_eff != 0 && $urandom_range(1, 0) == 1)
                        addr = DIMENSION - w_eff + $urandom_range(w_eff - 1, 0);
                    else
                        addr = $urandom_range(DIMENSION - 1, 0);
                    queue_item(CMD_READ_COEF, addr, $urandom);
                end else if (roll < 22) begin
                    queue_item(CMD_READ_BLK, ($urandom_range(3, 0) == 0)
                               ? $urandom_range(DIMENSION - 1, 0)
                               : $urandom_range(NUM_BLOCKS - 1, 0), $urandom);
                end else if (roll < 24) begin
                    queue_item(CMD_SIGN, $urandom_range(SIGN_SLOTS - 1, 0), $urandom);
                end
                queue_item(CMD_POS, $urandom, position_word());
            end

            for (int b = 0; b < NUM_BLOCKS; b++)
                queue_item(CMD_READ_BLK, b, $urandom);
            for (int k = 0; k < 4; k++) begin
                addr = (w_eff != 0) ? DIMENSION - w_eff + $urandom_range(w_eff - 1, 0)
                                    : $urandom_range(DIMENSION - 1, 0);
                queue_item(CMD_READ_COEF, addr, $urandom);
            end

            // receiver holds off while the sender keeps offering
            if (seq == 1)
                hold_requests <= hold_requests + 1;
            seq++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
